// File: hw/rtl/dbpc_pkg.sv
// dbpc_pkg: shared types and codes for the debounce / edge / press classifier
// holds state codes, press codes, register indexes, config and result structs
// no dependencies
package dbpc_pkg;

	// width of the 16-bit timing registers
	localparam int unsigned CFG_TIME_W = 16;
	localparam int unsigned CFG_IDX_W  = 2;

	// debounced state codes
	localparam logic [1:0] ST_LOW     = 2'd0;
	localparam logic [1:0] ST_HIGH    = 2'd1;
	localparam logic [1:0] ST_FALLING = 2'd2;
	localparam logic [1:0] ST_RISING  = 2'd3;

	// edge pulse modes
	localparam logic [1:0] EDGE_NONE    = 2'd0;
	localparam logic [1:0] EDGE_RISING  = 2'd1;
	localparam logic [1:0] EDGE_FALLING = 2'd2;
	localparam logic [1:0] EDGE_BOTH    = 2'd3;

	// press classification codes
	localparam logic [1:0] PRESS_NONE  = 2'd0;
	localparam logic [1:0] PRESS_SHORT = 2'd1;
	localparam logic [1:0] PRESS_LONG  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_SELECT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_LIMIT = 2'd2;

	localparam logic [CFG_TIME_W-1:0] LONG_PRESS_LIMIT_RST = 16'd1000;

	typedef struct packed {
		logic [CFG_TIME_W-1:0] sample_interval;
		logic [1:0]            edge_select;
		logic [CFG_TIME_W-1:0] long_press_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0] level_state;
		logic       edge_pulse;
		logic       state_changed;
		logic [1:0] press_event;
		logic       risen_seen;
		logic       fallen_seen;
	} result_t;

endpackage

// File: hw/rtl/dbpc_core.sv
// dbpc_core: debounce state, sticky flags and press timer for one tick item
// computes the result of the current item combinationally, updates on advance
// depends on dbpc_pkg
module dbpc_core #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  dbpc_pkg::cfg_t    cfg,
	input  logic              raw_sample,
	input  logic              read_risen,
	input  logic              read_fallen,
	output dbpc_pkg::result_t result
);

	localparam int unsigned CMP_W = (TIMER_BITS > dbpc_pkg::CFG_TIME_W) ?
		TIMER_BITS : dbpc_pkg::CFG_TIME_W;
	localparam logic [TIMER_BITS-1:0] TMAX = '1;

	logic [TIMER_BITS-1:0] tss_q, press_ticks_q;
	logic                  prev_q, stable_q, rise_q, fall_q, long_rep_q;
	logic [1:0]            reported_q;

	logic [TIMER_BITS-1:0] tss_inc, press_inc, tss_d, press_d;
	logic                  interval_zero, take;
	logic                  set_rise, set_fall, stable_d;
	logic [1:0]            st;
	logic                  rise_all, fall_all, long_rep_d;
	logic                  below_limit;
	logic [1:0]            press;
	logic                  pulse;

	// saturating timers
	assign tss_inc   = (tss_q == TMAX) ? tss_q : tss_q + 1'b1;
	assign press_inc = (press_ticks_q == TMAX) ? press_ticks_q : press_ticks_q + 1'b1;

	assign interval_zero = (cfg.sample_interval == '0);
	assign take = interval_zero ||
		(CMP_W'(tss_inc) >= CMP_W'(cfg.sample_interval));
	assign tss_d = (take && !interval_zero) ? '0 : tss_inc;

	// two equal samples differing from the stable level make an edge
	assign set_rise = take && (raw_sample == prev_q) && raw_sample && !stable_q;
	assign set_fall = take && (raw_sample == prev_q) && !raw_sample && stable_q;
	assign stable_d = (set_rise || set_fall) ? raw_sample : stable_q;

	// pending level between ticks always follows the stable level
	always_comb begin
		if (set_rise) begin
			st = dbpc_pkg::ST_RISING;
		end else if (set_fall) begin
			st = dbpc_pkg::ST_FALLING;
		end else if (stable_q) begin
			st = dbpc_pkg::ST_HIGH;
		end else begin
			st = dbpc_pkg::ST_LOW;
		end
	end

	always_comb begin
		unique case (cfg.edge_select)
			dbpc_pkg::EDGE_RISING:  pulse = (st == dbpc_pkg::ST_RISING);
			dbpc_pkg::EDGE_FALLING: pulse = (st == dbpc_pkg::ST_FALLING);
			dbpc_pkg::EDGE_BOTH:    pulse = (st == dbpc_pkg::ST_RISING) ||
				(st == dbpc_pkg::ST_FALLING);
			default:                pulse = 1'b0;
		endcase
	end

	// press classification; a falling edge restarts the timer
	assign below_limit = CMP_W'(press_inc) < CMP_W'(cfg.long_press_limit);

	always_comb begin
		press      = dbpc_pkg::PRESS_NONE;
		long_rep_d = long_rep_q;
		press_d    = press_inc;
		if (st == dbpc_pkg::ST_FALLING) begin
			press_d    = '0;
			long_rep_d = 1'b0;
		end else if (st == dbpc_pkg::ST_RISING && below_limit) begin
			press = dbpc_pkg::PRESS_SHORT;
		end else if (st == dbpc_pkg::ST_HIGH && !long_rep_q && !below_limit) begin
			press      = dbpc_pkg::PRESS_LONG;
			long_rep_d = 1'b1;
		end
	end

	// sticky flags, set before the read in the same tick
	assign rise_all = rise_q | set_rise;
	assign fall_all = fall_q | set_fall;

	assign result.level_state   = st;
	assign result.edge_pulse    = pulse;
	assign result.state_changed = (reported_q != st);
	assign result.press_event   = press;
	assign result.risen_seen    = read_risen & rise_all;
	assign result.fallen_seen   = read_fallen & fall_all;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tss_q         <= '0;
			press_ticks_q <= '0;
			prev_q        <= 1'b0;
			stable_q      <= 1'b0;
			rise_q        <= 1'b0;
			fall_q        <= 1'b0;
			long_rep_q    <= 1'b0;
			reported_q    <= dbpc_pkg::ST_LOW;
		end else if (advance) begin
			tss_q         <= tss_d;
			press_ticks_q <= press_d;
			if (take) begin
				prev_q <= raw_sample;
			end
			stable_q      <= stable_d;
			rise_q        <= rise_all & ~read_risen;
			fall_q        <= fall_all & ~read_fallen;
			long_rep_q    <= long_rep_d;
			reported_q    <= st;
		end
	end

endmodule

// File: hw/rtl/debounce_edge_press_classifier.sv
// debounce_edge_press_classifier: top level, config registers and result buffer
// instantiates dbpc_core, depends on dbpc_pkg
//
// channel   direction  handshake              payload
// tick      in         tick_valid/tick_stall  raw_sample, read_risen, read_fallen
// result    out        result_valid/stall     level_state .. fallen_seen
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// one tick item per clock while tick_stall is low, set by the single
// combinational pass through dbpc_core; the result lands in the output register
// at the accept edge, or a skid register takes one more item while the output
// register is stalled, so tick_stall rises only when both are full
// reset is asynchronous, active low; config resets to interval 0, no edge
// pulse, long press limit 1000
module debounce_edge_press_classifier #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// tick items
	input  logic                          tick_valid,
	output logic                          tick_stall,
	input  logic                          raw_sample,
	input  logic                          read_risen,
	input  logic                          read_fallen,
	// result items
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [1:0]                    level_state,
	output logic                          edge_pulse,
	output logic                          state_changed,
	output logic [1:0]                    press_event,
	output logic                          risen_seen,
	output logic                          fallen_seen,
	// register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dbpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dbpc_pkg::CFG_TIME_W-1:0] cfg_data
);

	dbpc_pkg::cfg_t    cfg_q;
	dbpc_pkg::result_t core_res;
	dbpc_pkg::result_t out_q, skid_q;
	logic              out_valid_q, skid_valid_q;
	logic              tick_accept, result_take;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_interval  <= '0;
			cfg_q.edge_select      <= dbpc_pkg::EDGE_NONE;
			cfg_q.long_press_limit <= dbpc_pkg::LONG_PRESS_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dbpc_pkg::REG_SAMPLE_INTERVAL:  cfg_q.sample_interval  <= cfg_data;
				dbpc_pkg::REG_EDGE_SELECT:      cfg_q.edge_select      <= cfg_data[1:0];
				dbpc_pkg::REG_LONG_PRESS_LIMIT: cfg_q.long_press_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	// stall only while the skid register holds an item
	assign tick_stall  = skid_valid_q;
	assign tick_accept = tick_valid && !tick_stall;
	assign result_take = out_valid_q && !result_stall;

	dbpc_core #(
		.TIMER_BITS(TIMER_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (tick_accept),
		.cfg        (cfg_q),
		.raw_sample (raw_sample),
		.read_risen (read_risen),
		.read_fallen(read_fallen),
		.result     (core_res)
	);

	// output register plus skid: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (result_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (tick_accept) begin
			if (!out_valid_q || result_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (result_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (result_take) begin
				out_q <= skid_q;
			end
		end else if (tick_accept) begin
			if (!out_valid_q || result_take) begin
				out_q <= core_res;
			end else begin
				skid_q <= core_res;
			end
		end
	end

	assign result_valid  = out_valid_q;
	assign level_state   = out_q.level_state;
	assign edge_pulse    = out_q.edge_pulse;
	assign state_changed = out_q.state_changed;
	assign press_event   = out_q.press_event;
	assign risen_seen    = out_q.risen_seen;
	assign fallen_seen   = out_q.fallen_seen;

	// skid holds an item only behind a full output register
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
	else $error("skid register full while output register empty");

	// an accepted tick always leaves result_valid high in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(tick_valid && !tick_stall) |=> result_valid)
	else $error("accepted tick produced no result");

	// an edge state is always a change from the previous tick
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (level_state == dbpc_pkg::ST_RISING ||
			level_state == dbpc_pkg::ST_FALLING)) |-> state_changed)
	else $error("edge reported without state change");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for debounce_edge_press_classifier
// drives tick items and register writes, predicts each result item, compares in order
// depends on dbpc_pkg and the debounce_edge_press_classifier rtl
module testbench;

	localparam int TIMER_W     = 16;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_TICKS  = 200;
	localparam int STORM_ITEMS = 60;
	localparam int STORM_COUNT = 10;
	localparam int MAX_REPORTS = 20;
	localparam logic [dbpc_pkg::CFG_TIME_W-1:0] HOLD_LIMIT = 16'd150;

	localparam logic OFF = 1'b0;
	localparam logic ON  = 1'b1;
	localparam dbpc_pkg::result_t NO_RES = dbpc_pkg::result_t'('0);

	// one row of the directed table: optional register set, one tick, optional typed result
	typedef struct packed {
		logic                            load_cfg;
		logic [dbpc_pkg::CFG_TIME_W-1:0] interval;
		logic [1:0]                      edge_mode;
		logic [dbpc_pkg::CFG_TIME_W-1:0] limit;
		logic                            raw;
		logic                            rd_rise;
		logic                            rd_fall;
		logic                            typed;
		dbpc_pkg::result_t               want;
	} tick_row_t;

	// rows 0..8 run on reset settings and carry typed results:
	// quiet start, a clean rise right after reset (short press, flag read in the edge tick),
	// a fall, a flag read one tick later, then a one-tick glitch that must be filtered
	// next: zero limit with both edges pulsed, so the first high tick is a long press
	// then a sample interval of 3 with the largest limit, then the largest interval
	localparam tick_row_t DIRECTED_ROWS [24] = '{
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, OFF, ON,  ON,  ON,
			'{dbpc_pkg::ST_LOW,     OFF, OFF, dbpc_pkg::PRESS_NONE,  OFF, OFF}},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, ON,  OFF, OFF, ON,
			'{dbpc_pkg::ST_LOW,     OFF, OFF, dbpc_pkg::PRESS_NONE,  OFF, OFF}},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, ON,  ON,  OFF, ON,
			'{dbpc_pkg::ST_RISING,  OFF, ON,  dbpc_pkg::PRESS_SHORT, ON,  OFF}},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, ON,  ON,  ON,  ON,
			'{dbpc_pkg::ST_HIGH,    OFF, ON,  dbpc_pkg::PRESS_NONE,  OFF, OFF}},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, OFF, OFF, OFF, ON,
			'{dbpc_pkg::ST_HIGH,    OFF, OFF, dbpc_pkg::PRESS_NONE,  OFF, OFF}},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, OFF, OFF, OFF, ON,
			'{dbpc_pkg::ST_FALLING, OFF, ON,  dbpc_pkg::PRESS_NONE,  OFF, OFF}},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, OFF, OFF, ON,  ON,
			'{dbpc_pkg::ST_LOW,     OFF, ON,  dbpc_pkg::PRESS_NONE,  OFF, ON }},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, ON,  OFF, ON,  ON,
			'{dbpc_pkg::ST_LOW,     OFF, OFF, dbpc_pkg::PRESS_NONE,  OFF, OFF}},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, OFF, OFF, OFF, ON,
			'{dbpc_pkg::ST_LOW,     OFF, OFF, dbpc_pkg::PRESS_NONE,  OFF, OFF}},
		'{ON,  16'd0, dbpc_pkg::EDGE_BOTH, 16'd0, ON,  OFF, OFF, OFF, NO_RES},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, ON,  ON,  OFF, OFF, NO_RES},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, ON,  OFF, OFF, OFF, NO_RES},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, OFF, OFF, OFF, OFF, NO_RES},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, OFF, OFF, ON,  OFF, NO_RES},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, OFF, ON,  ON,  OFF, NO_RES},
		'{ON,  16'd3, dbpc_pkg::EDGE_RISING, 16'hFFFF, ON, OFF, OFF, OFF, NO_RES},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, ON,  OFF, OFF, OFF, NO_RES},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, ON,  OFF, OFF, OFF, NO_RES},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, ON,  OFF, OFF, OFF, NO_RES},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, ON,  OFF, OFF, OFF, NO_RES},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, ON,  OFF, OFF, OFF, NO_RES},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, ON,  ON,  ON,  OFF, NO_RES},
		'{ON,  16'hFFFF, dbpc_pkg::EDGE_FALLING, 16'd5, OFF, OFF, OFF, OFF, NO_RES},
		'{OFF, 16'd0, dbpc_pkg::EDGE_NONE, 16'd0, OFF, ON,  ON,  OFF, NO_RES}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// tick channel
	logic tick_valid = 1'b0;
	logic tick_stall;
	logic raw_sample = 1'b0;
	logic read_risen = 1'b0;
	logic read_fallen = 1'b0;

	// result channel
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [1:0] level_state;
	logic       edge_pulse;
	logic       state_changed;
	logic [1:0] press_event;
	logic       risen_seen;
	logic       fallen_seen;

	// register write channel
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [dbpc_pkg::CFG_IDX_W-1:0]  cfg_index = dbpc_pkg::REG_SAMPLE_INTERVAL;
	logic [dbpc_pkg::CFG_TIME_W-1:0] cfg_data = '0;

	// register shadow, reset values of the block
	logic [dbpc_pkg::CFG_TIME_W-1:0] cf_interval = '0;
	logic [1:0]                      cf_edge     = dbpc_pkg::EDGE_NONE;
	logic [dbpc_pkg::CFG_TIME_W-1:0] cf_limit    = dbpc_pkg::LONG_PRESS_LIMIT_RST;

	// debouncer state as the predictor sees it
	logic [TIMER_W-1:0] tk_since    = '0;
	logic               last_raw    = 1'b0;
	logic               settled     = 1'b0;
	logic [1:0]         next_state  = dbpc_pkg::ST_LOW;
	logic [1:0]         shown_state = dbpc_pkg::ST_LOW;
	logic               rise_sticky = 1'b0;
	logic               fall_sticky = 1'b0;
	logic [TIMER_W-1:0] hold_ticks  = '0;
	logic               long_sent   = 1'b0;

	dbpc_pkg::result_t expected_q[$];
	dbpc_pkg::result_t got_res;
	dbpc_pkg::result_t want_res;

	int  errors     = 0;
	int  n_items    = 0;
	int  n_results  = 0;
	int  n_settings = 0;
	int  stall_left = 0;
	int  cycles     = 0;
	bit  no_gaps    = 1'b0;
	logic cur_level = 1'b0;

	debounce_edge_press_classifier #(
		.TIMER_BITS(TIMER_W)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.raw_sample   (raw_sample),
		.read_risen   (read_risen),
		.read_fallen  (read_fallen),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.level_state  (level_state),
		.edge_pulse   (edge_pulse),
		.state_changed(state_changed),
		.press_event  (press_event),
		.risen_seen   (risen_seen),
		.fallen_seen  (fallen_seen),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// debounce, edge flags and press timing for one tick, in block order:
	// timers first, then the sample, then the reported state, then the press event, then the flag reads
	function automatic dbpc_pkg::result_t classify_tick(input logic raw, input logic rd_r,
			input logic rd_f);
		dbpc_pkg::result_t r;
		logic [1:0] st;
		r = '0;
		if (tk_since != '1) tk_since = tk_since + 1'b1;
		if (hold_ticks != '1) hold_ticks = hold_ticks + 1'b1;

		if (cf_interval == '0 || tk_since >= cf_interval) begin
			if (cf_interval != '0) tk_since = '0;
			// two equal samples in a row move the stable level
			if (raw == last_raw) begin
				if (raw != settled) begin
					settled = raw;
					if (raw) begin
						next_state  = dbpc_pkg::ST_RISING;
						rise_sticky = 1'b1;
					end else begin
						next_state  = dbpc_pkg::ST_FALLING;
						fall_sticky = 1'b1;
					end
				end else begin
					next_state = raw ? dbpc_pkg::ST_HIGH : dbpc_pkg::ST_LOW;
				end
			end
			last_raw = raw;
		end

		r.state_changed = (shown_state != next_state);
		shown_state     = next_state;
		st              = next_state;
		r.level_state   = st;
		r.edge_pulse    = (cf_edge == dbpc_pkg::EDGE_RISING && st == dbpc_pkg::ST_RISING) ||
			(cf_edge == dbpc_pkg::EDGE_FALLING && st == dbpc_pkg::ST_FALLING) ||
			(cf_edge == dbpc_pkg::EDGE_BOTH &&
			(st == dbpc_pkg::ST_RISING || st == dbpc_pkg::ST_FALLING));

		// an edge is shown for one tick only
		if (next_state == dbpc_pkg::ST_RISING) next_state = dbpc_pkg::ST_HIGH;
		if (next_state == dbpc_pkg::ST_FALLING) next_state = dbpc_pkg::ST_LOW;

		// press timer restarts on the falling edge
		if (st == dbpc_pkg::ST_FALLING) begin
			hold_ticks = '0;
			long_sent  = 1'b0;
		end
		if (st == dbpc_pkg::ST_RISING && hold_ticks < cf_limit) begin
			r.press_event = dbpc_pkg::PRESS_SHORT;
		end else if (st == dbpc_pkg::ST_HIGH && !long_sent && hold_ticks >= cf_limit) begin
			long_sent     = 1'b1;
			r.press_event = dbpc_pkg::PRESS_LONG;
		end

		// reads see the flags after this tick's update and clear them
		if (rd_r) begin
			r.risen_seen = rise_sticky;
			rise_sticky  = 1'b0;
		end
		if (rd_f) begin
			r.fallen_seen = fall_sticky;
			fall_sticky   = 1'b0;
		end
		return r;
	endfunction

	// idle length for either side: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	// offer one tick item, wait for it to be taken, queue its expected result
	task automatic push_tick(input logic raw, input logic rd_r, input logic rd_f,
			input logic typed, input dbpc_pkg::result_t want);
		int gap;
		dbpc_pkg::result_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			tick_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_valid  <= 1'b1;
		raw_sample  <= raw;
		read_risen  <= rd_r;
		read_fallen <= rd_f;
		do @(posedge clk); while (!(tick_valid && !tick_stall));
		predicted = classify_tick(raw, rd_r, rd_f);
		// typed rows keep the predictor in step but check against the hand value
		expected_q.push_back(typed ? want : predicted);
		n_items++;
	endtask

	// stop sending and wait until every result has come back
	task automatic settle_results();
		tick_valid <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
	endtask

	// write all three registers back to back, only while the block is idle
	task automatic program_regs(input logic [dbpc_pkg::CFG_TIME_W-1:0] interval,
			input logic [1:0] edge_mode, input logic [dbpc_pkg::CFG_TIME_W-1:0] limit);
		logic [dbpc_pkg::CFG_IDX_W-1:0]  idx_list [3];
		logic [dbpc_pkg::CFG_TIME_W-1:0] val_list [3];
		idx_list = '{dbpc_pkg::REG_SAMPLE_INTERVAL, dbpc_pkg::REG_EDGE_SELECT,
			dbpc_pkg::REG_LONG_PRESS_LIMIT};
		val_list = '{interval, {{(dbpc_pkg::CFG_TIME_W-2){1'b0}}, edge_mode}, limit};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx_list[i];
			cfg_data  <= val_list[i];
			do @(posedge clk); while (!(cfg_valid && cfg_ready));
			case (idx_list[i])
				dbpc_pkg::REG_SAMPLE_INTERVAL: cf_interval = val_list[i];
				dbpc_pkg::REG_EDGE_SELECT:     cf_edge = val_list[i][1:0];
				default:                       cf_limit = val_list[i];
			endcase
		end
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// button activity: level changes with contact bounce, held runs around the
	// sample interval and press limit, rare one-tick noise, random flag reads
	task automatic press_storm(input int count);
		int sent;
		int run;
		int span;
		int bounce;
		logic raw;
		sent = 0;
		span = ((cf_interval > 8) ? 8 : int'(cf_interval) + 1) * 3 +
			((cf_limit > 48) ? 48 : int'(cf_limit)) + 2;
		while (sent < count) begin
			cur_level = ~cur_level;
			if ($urandom_range(0, 2) == 0) begin
				bounce = $urandom_range(1, 4);
				for (int k = 0; k < bounce; k++) begin
					push_tick(k[0] ? ~cur_level : cur_level, $urandom_range(0, 3) == 0,
						$urandom_range(0, 3) == 0, OFF, NO_RES);
					sent++;
				end
			end
			run = $urandom_range(1, span);
			for (int k = 0; k < run; k++) begin
				raw = ($urandom_range(0, 19) == 0) ? ~cur_level : cur_level;
				push_tick(raw, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
					OFF, NO_RES);
				sent++;
				// now and then let everything drain before going on
				if ($urandom_range(0, 199) == 0) settle_results();
			end
		end
	endtask

	// result side: compare each taken result with the oldest expectation
	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			got_res = {level_state, edge_pulse, state_changed, press_event,
				risen_seen, fallen_seen};
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result item with nothing expected: state=%0d press=%0d",
						$realtime, level_state, press_event);
			end else begin
				want_res = expected_q.pop_front();
				n_results++;
				if (got_res !== want_res) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display({"%0t: result %0d expected state=%0d pulse=%0b chg=%0b ",
							"press=%0d risen=%0b fallen=%0b, actual state=%0d pulse=%0b ",
							"chg=%0b press=%0d risen=%0b fallen=%0b"},
							$realtime, n_results, want_res.level_state,
							want_res.edge_pulse, want_res.state_changed,
							want_res.press_event, want_res.risen_seen,
							want_res.fallen_seen, got_res.level_state,
							got_res.edge_pulse, got_res.state_changed,
							got_res.press_event, got_res.risen_seen,
							got_res.fallen_seen);
				end
			end
		end
		// receiver stalls in random stretches, or never in gap-free phases
		if (stall_left == 0) stall_left = pick_gap();
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_q.size());
			$display("debounce_edge_press_classifier: mismatch");
			$finish;
		end
	end

	initial begin
		logic [dbpc_pkg::CFG_TIME_W-1:0] iv;
		logic [dbpc_pkg::CFG_TIME_W-1:0] lim;
		int pick;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed table: register sets only at idle points
		foreach (DIRECTED_ROWS[i]) begin
			if (DIRECTED_ROWS[i].load_cfg) begin
				settle_results();
				program_regs(DIRECTED_ROWS[i].interval, DIRECTED_ROWS[i].edge_mode,
					DIRECTED_ROWS[i].limit);
			end
			push_tick(DIRECTED_ROWS[i].raw, DIRECTED_ROWS[i].rd_rise,
				DIRECTED_ROWS[i].rd_fall, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
		end

		// long hold with every-tick sampling: the long press fires once, when
		// the press timer reaches the limit
		settle_results();
		program_regs('0, dbpc_pkg::EDGE_BOTH, HOLD_LIMIT);
		no_gaps = 1'b1;
		push_tick(OFF, OFF, OFF, OFF, NO_RES);
		push_tick(OFF, OFF, ON, OFF, NO_RES);
		for (int k = 0; k < HOLD_TICKS; k++)
			push_tick(ON, OFF, OFF, OFF, NO_RES);
		// largest interval: the sample timer is far below it, so no sample is taken
		settle_results();
		program_regs('1, dbpc_pkg::EDGE_RISING, '1);
		for (int k = 0; k < 4; k++)
			push_tick(OFF, ON, ON, OFF, NO_RES);
		cur_level = OFF;

		// random phases, each with its own settings
		for (int ph = 0; ph < STORM_COUNT; ph++) begin
			settle_results();
			pick = $urandom_range(0, 9);
			iv = (pick < 4) ? '0 : (pick == 4) ? '1 :
				dbpc_pkg::CFG_TIME_W'($urandom_range(1, 4));
			pick = $urandom_range(0, 9);
			lim = (pick == 0) ? '0 : (pick == 1) ? '1 :
				dbpc_pkg::CFG_TIME_W'($urandom_range(1, 40));
			program_regs(iv, 2'($urandom_range(0, 3)), lim);
			no_gaps = ($urandom_range(0, 3) == 0);
			press_storm(STORM_ITEMS);
		end

		// drain, then let the clock run on before the summary
		settle_results();
		repeat (4) @(posedge clk);

		$display("covered %0d tick items and %0d results over %0d register settings",
			n_items, n_results, n_settings);
		$display("incl. filtered glitches, flag reads on edge ticks, zero and full-scale limits");
		if (errors == 0) begin
			$display("debounce_edge_press_classifier: match");
		end else begin
			$display("%0d mismatching results", errors);
			$display("debounce_edge_press_classifier: mismatch");
		end
		$finish;
	end

endmodule
